>>> src/dqnc_pkg.sv
// Shared types, constants and helper functions for the quadtree node count unit.
// Used by dqnc_ctrl, dqnc_datapath and dynamic_quadtree_node_count_unit.
`timescale 1ns / 1ps

package dqnc_pkg;

    // Default largest image side, as log2
    localparam int DEF_MAX_SIZE_LOG2 = 8;
    // Size register value after reset
    localparam int SIZE_LOG2_RESET   = 8;

    // Item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FLIP = 1'b1;

    // Block status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_WHITE = 2'd0;
    localparam t_status ST_BLACK = 2'd1;
    localparam t_status ST_MIXED = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PIX_RD,
        S_PIX_WR,
        S_BLK_RD,
        S_BLK_WR,
        S_ROOT,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;     // take the input item
        logic clear;     // write one clearing step
        logic pix_rd;    // read the pixel quad on the path
        logic pix_wr;    // update the pixel, rewrite its quad
        logic blk_rd;    // read the status quad at the current level
        logic blk_wr;    // update one status, rewrite its quad
        logic root;      // update the root status
        logic load_out;  // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // clearing sweep at its last entry
        logic skip;      // no path update for this item
        logic s_one;     // image side is two
        logic lvl_last;  // current level sits just below the root
        logic is_flip;   // item asks for a result
        logic out_busy;  // result register full and stalled
    } t_dp_sts;

    // First quad address of the tree layer that is d levels below the root
    function automatic logic [31:0] quad_base(input logic [4:0] d);
        logic [31:0] b;
        b = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < int'(d)) begin
                b[2*i] = 1'b1;
            end
        end
        return b;
    endfunction

    // Status of a block from the statuses of its four quarters
    function automatic t_status merge_quad(input logic [7:0] q);
        t_status a, b, e, f;
        a = q[1:0];
        b = q[3:2];
        e = q[5:4];
        f = q[7:6];
        if (a == b && b == e && e == f && a != ST_MIXED) begin
            return a;
        end
        return ST_MIXED;
    endfunction

endpackage

>>> src/dqnc_ctrl.sv
// Controller state machine of the quadtree node count unit.
// Depends on dqnc_pkg; drives dqnc_datapath through t_dp_cmd.
`timescale 1ns / 1ps

module dqnc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_cfg_we,
    input  dqnc_pkg::t_dp_sts i_sts,
    output dqnc_pkg::t_dp_cmd o_cmd,
    output logic             o_in_stall
);

    dqnc_pkg::t_state r_state;
    dqnc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqnc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            dqnc_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = dqnc_pkg::S_IDLE;
                end
            end
            dqnc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = dqnc_pkg::S_PIX_RD;
                end
            end
            dqnc_pkg::S_PIX_RD: begin
                if (i_sts.skip) begin
                    n_state = dqnc_pkg::S_DONE;
                end else begin
                    o_cmd.pix_rd = 1'b1;
                    n_state      = dqnc_pkg::S_PIX_WR;
                end
            end
            dqnc_pkg::S_PIX_WR: begin
                o_cmd.pix_wr = 1'b1;
                n_state = i_sts.s_one ? dqnc_pkg::S_ROOT : dqnc_pkg::S_BLK_RD;
            end
            dqnc_pkg::S_BLK_RD: begin
                o_cmd.blk_rd = 1'b1;
                n_state      = dqnc_pkg::S_BLK_WR;
            end
            dqnc_pkg::S_BLK_WR: begin
                o_cmd.blk_wr = 1'b1;
                n_state = i_sts.lvl_last ? dqnc_pkg::S_ROOT : dqnc_pkg::S_BLK_RD;
            end
            dqnc_pkg::S_ROOT: begin
                o_cmd.root = 1'b1;
                n_state    = dqnc_pkg::S_DONE;
            end
            dqnc_pkg::S_DONE: begin
                if (!i_sts.is_flip) begin
                    n_state = dqnc_pkg::S_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = dqnc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dqnc_pkg::S_CLEAR;
            end
        endcase
        // A size write restarts the clearing sweep
        if (i_cfg_we) begin
            n_state = dqnc_pkg::S_CLEAR;
        end
    end

    assign o_in_stall = (r_state != dqnc_pkg::S_IDLE);

    // A status rewrite always follows its own read
    a_blk_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dqnc_pkg::S_BLK_WR) |-> ($past(r_state) == dqnc_pkg::S_BLK_RD))
        else $error("status rewrite without a preceding read");

    // A finished item with a free result register returns to idle
    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dqnc_pkg::S_DONE && !i_sts.out_busy && !i_cfg_we)
        |=> (r_state == dqnc_pkg::S_IDLE))
        else $error("finished item did not release the unit");

endmodule

>>> src/dqnc_datapath.sv
// Datapath of the quadtree node count unit: pixel and status quad memories,
// path registers, mixed block counter and result register. Depends on dqnc_pkg.
`timescale 1ns / 1ps

module dqnc_datapath #(
    parameter int MAX_SIZE_LOG2 = dqnc_pkg::DEF_MAX_SIZE_LOG2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_cmd,
    input  logic [7:0]        i_row,
    input  logic [7:0]        i_col,
    input  logic              i_pixel_value,
    input  logic              i_out_stall,
    input  dqnc_pkg::t_dp_cmd i_dp_cmd,
    output dqnc_pkg::t_dp_sts o_sts,
    output logic              o_out_valid,
    output logic [16:0]       o_node_count,
    output logic              o_bad_coordinate
);

    // Levels below the root that hold quads
    localparam int QL        = (MAX_SIZE_LOG2 > 1) ? MAX_SIZE_LOG2 - 1 : 0;
    localparam int PQD       = 1 << (2 * QL);
    localparam int AWP       = (QL > 0) ? 2 * QL : 1;
    localparam int BQD_RAW   = ((1 << (2 * QL)) - 1) / 3;
    localparam int BQD       = (BQD_RAW > 1) ? BQD_RAW : 1;
    localparam int AWB       = (BQD > 1) ? $clog2(BQD) : 1;
    localparam int SW        = (MAX_SIZE_LOG2 > 0) ? $clog2(MAX_SIZE_LOG2 + 1) : 1;
    localparam int MW        = (MAX_SIZE_LOG2 > 0) ? 2 * MAX_SIZE_LOG2 - 1 : 1;
    localparam int BLK_TOTAL = ((1 << (2 * MAX_SIZE_LOG2)) - 1) / 3;
    localparam int SIZE_RST  = (dqnc_pkg::SIZE_LOG2_RESET > MAX_SIZE_LOG2) ?
                               MAX_SIZE_LOG2 : dqnc_pkg::SIZE_LOG2_RESET;

    // Pixel quads (2x2 pixels) and status quads (four sibling blocks)
    logic [3:0] pix_mem [PQD];
    logic [7:0] blk_mem [BQD];

    logic [SW-1:0]     r_size;
    logic              r_cmd;
    logic [7:0]        r_row;
    logic [7:0]        r_col;
    logic              r_val;
    logic              r_bad;
    logic [SW-1:0]     r_lvl;
    dqnc_pkg::t_status r_ns;
    dqnc_pkg::t_status r_root;
    logic [MW-1:0]     r_mixed;
    logic [AWP-1:0]    r_clr;
    logic [3:0]        r_pq;
    logic [7:0]        r_bq;
    logic              r_out_valid;
    logic [16:0]       r_out_count;
    logic              r_out_bad;

    logic [SW-1:0]     size_sm1;
    logic [SW-1:0]     lvl_p1;
    logic [SW-1:0]     depth_d;
    logic [AWP-1:0]    pix_addr;
    logic [AWB-1:0]    blk_addr;
    logic              in_bad;
    logic [1:0]        pix_sel;
    logic              pix_new;
    logic [3:0]        pq_new;
    logic [7:0]        pq_ext;
    logic [7:0]        row_sh;
    logic [7:0]        col_sh;
    logic [1:0]        blk_sel;
    logic [7:0]        bq_new;
    dqnc_pkg::t_status slot_old;
    dqnc_pkg::t_status os;
    logic              cnt_inc;
    logic              cnt_dec;

    // Path addresses
    assign size_sm1 = r_size - 1'b1;
    assign lvl_p1   = r_lvl + 1'b1;
    assign depth_d  = r_size - lvl_p1;
    assign pix_addr = AWP'(((32'(r_row) >> 1) << size_sm1) | (32'(r_col) >> 1));
    assign blk_addr = AWB'(dqnc_pkg::quad_base(5'(depth_d))
                    + (((32'(r_row) >> lvl_p1) << depth_d) | (32'(r_col) >> lvl_p1)));
    assign in_bad   = ((i_row >> r_size) != 8'd0) || ((i_col >> r_size) != 8'd0);

    // Pixel update within its quad
    assign pix_sel = {r_row[0], r_col[0]};
    assign pix_new = (r_cmd == dqnc_pkg::CMD_FLIP) ? ~r_pq[pix_sel] : r_val;
    always_comb begin
        pq_new          = r_pq;
        pq_new[pix_sel] = pix_new;
    end
    assign pq_ext = {1'b0, pq_new[3], 1'b0, pq_new[2], 1'b0, pq_new[1], 1'b0, pq_new[0]};

    // Status update within its quad
    assign row_sh   = r_row >> r_lvl;
    assign col_sh   = r_col >> r_lvl;
    assign blk_sel  = {row_sh[0], col_sh[0]};
    assign slot_old = r_bq[2*blk_sel +: 2];
    always_comb begin
        bq_new              = r_bq;
        bq_new[2*blk_sel +: 2] = r_ns;
    end

    // Mixed count change for the block being rewritten
    assign os      = i_dp_cmd.root ? r_root : slot_old;
    assign cnt_inc = (i_dp_cmd.blk_wr || i_dp_cmd.root)
                  && (os != dqnc_pkg::ST_MIXED) && (r_ns == dqnc_pkg::ST_MIXED);
    assign cnt_dec = (i_dp_cmd.blk_wr || i_dp_cmd.root)
                  && (os == dqnc_pkg::ST_MIXED) && (r_ns != dqnc_pkg::ST_MIXED);

    // Pixel quad memory
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.clear) begin
            pix_mem[r_clr] <= '0;
        end else if (i_dp_cmd.pix_wr) begin
            pix_mem[pix_addr] <= pq_new;
        end
        if (i_dp_cmd.pix_rd) begin
            r_pq <= pix_mem[pix_addr];
        end
    end

    // Status quad memory
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.clear) begin
            if (int'(r_clr) < BQD) begin
                blk_mem[AWB'(r_clr)] <= '0;
            end
        end else if (i_dp_cmd.blk_wr) begin
            blk_mem[blk_addr] <= bq_new;
        end
        if (i_dp_cmd.blk_rd) begin
            r_bq <= blk_mem[blk_addr];
        end
    end

    // Item registers and path level
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.latch) begin
            r_cmd <= i_cmd;
            r_row <= i_row;
            r_col <= i_col;
            r_val <= i_pixel_value;
            r_bad <= in_bad;
        end
        if (i_dp_cmd.latch) begin
            r_lvl <= SW'(1);
        end else if (i_dp_cmd.blk_wr) begin
            r_lvl <= lvl_p1;
        end
        if (i_dp_cmd.pix_wr) begin
            r_ns <= dqnc_pkg::merge_quad(pq_ext);
        end else if (i_dp_cmd.blk_wr) begin
            r_ns <= dqnc_pkg::merge_quad(bq_new);
        end
    end

    // Size, clearing sweep, root status and mixed count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SW'(SIZE_RST);
            r_clr   <= '0;
            r_root  <= dqnc_pkg::ST_WHITE;
            r_mixed <= '0;
        end else if (i_cfg_we) begin
            r_size  <= (int'(i_cfg_data) > MAX_SIZE_LOG2) ? SW'(MAX_SIZE_LOG2)
                                                        : SW'(i_cfg_data);
            r_clr   <= '0;
            r_root  <= dqnc_pkg::ST_WHITE;
            r_mixed <= '0;
        end else begin
            if (i_dp_cmd.clear && !o_sts.clr_last) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_dp_cmd.root) begin
                r_root <= r_ns;
            end
            if (cnt_inc) begin
                r_mixed <= r_mixed + 1'b1;
            end else if (cnt_dec) begin
                r_mixed <= r_mixed - 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_out) begin
            r_out_count <= 17'({r_mixed, 2'b01});
            r_out_bad   <= r_bad;
        end
    end

    // Status back to the controller
    assign o_sts.clr_last = (r_clr == AWP'(PQD - 1));
    assign o_sts.skip     = r_bad || (r_size == '0);
    assign o_sts.s_one    = (r_size == SW'(1));
    assign o_sts.lvl_last = (lvl_p1 == r_size);
    assign o_sts.is_flip  = (r_cmd == dqnc_pkg::CMD_FLIP);
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_node_count     = r_out_count;
    assign o_bad_coordinate = r_out_bad;

    // The mixed count never exceeds the number of blocks
    a_mixed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_mixed) <= BLK_TOTAL)
        else $error("mixed block count out of range");

    // A mixed root is always counted
    a_root_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_root == dqnc_pkg::ST_MIXED) |-> (r_mixed != '0))
        else $error("mixed root without a mixed count");

    // Status quads are rewritten only strictly between the pixels and the root
    a_blk_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.blk_wr |-> (r_lvl != '0) && (lvl_p1 <= r_size))
        else $error("status quad rewritten at a level outside the tree");

    // Pixels are only touched for a good coordinate on a real image
    a_pix_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.pix_wr |-> !r_bad && (r_size != '0))
        else $error("pixel written for a skipped item");

endmodule

>>> src/dynamic_quadtree_node_count_unit.sv
// Top level of the quadtree node count unit: joins controller and datapath.
// Depends on dqnc_pkg, dqnc_ctrl and dqnc_datapath.
`timescale 1ns / 1ps

// Keeps a binary image of side 2^size_log2 and the white/black/mixed status of
// every quadtree block, and for each flip item returns 1 + 4 x (mixed blocks),
// the node count of the minimal region quadtree. Pixels sit in a memory of 2x2
// quads and block statuses in a memory of sibling quads, so each item does one
// read and one rewrite per tree level below the root and then updates the root
// status; an item whose coordinate is out of range, or any item when s = 0,
// skips the path. One item is worked on at a time, and the next item is taken
// once the unit is back in idle. A finished result waits in an output
// register while the next item is taken.
// After reset and after every size write the unit sweeps the pixel and status
// memories, one quad a cycle, and holds input stall high meanwhile.
module dynamic_quadtree_node_count_unit #(
    parameter int MAX_SIZE_LOG2 = dqnc_pkg::DEF_MAX_SIZE_LOG2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_col,
    input  logic        i_pixel_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [16:0] o_node_count,
    output logic        o_bad_coordinate
);

    dqnc_pkg::t_dp_cmd dp_cmd;
    dqnc_pkg::t_dp_sts dp_sts;

    // Sequencer
    dqnc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_we   (i_cfg_we),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    // Memories, path registers and result
    dqnc_datapath #(
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (i_cmd),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_pixel_value    (i_pixel_value),
        .i_out_stall      (i_out_stall),
        .i_dp_cmd         (dp_cmd),
        .o_sts            (dp_sts),
        .o_out_valid      (o_out_valid),
        .o_node_count     (o_node_count),
        .o_bad_coordinate (o_bad_coordinate)
    );

endmodule

>>> verif/dynamic_quadtree_node_count_unit_tb.sv
// Self-checking bench for dynamic_quadtree_node_count_unit: directed and random
// load/flip items over several image sizes, each count checked against a local model.
// Depends on dqnc_pkg and the unit under test only.
`timescale 1ns / 1ps

module dynamic_quadtree_node_count_unit_tb;

    localparam int MAX_LOG2      = dqnc_pkg::DEF_MAX_SIZE_LOG2;
    localparam int PIX_DEPTH     = 1 << (2 * MAX_LOG2);
    localparam int BLK_DEPTH     = (PIX_DEPTH - 1) / 3 + 1;
    // worst path walk plus margin, used before a size write and at the end
    localparam int SETTLE_CYCLES = 2 * MAX_LOG2 + 20;
    // covers the clearing sweep, during which no item moves, with margin
    localparam int QUIET_LIMIT   = 4 * (1 << (2 * (MAX_LOG2 - 1))) + 1000;

    typedef struct {
        logic [16:0] node_count;
        logic        bad_coordinate;
    } t_count_result;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [3:0]  i_cfg_data       = 4'd0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic        i_cmd            = dqnc_pkg::CMD_LOAD;
    logic [7:0]  i_row            = 8'd0;
    logic [7:0]  i_col            = 8'd0;
    logic        i_pixel_value    = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [16:0] o_node_count;
    logic        o_bad_coordinate;

    // model of the image, block statuses and size register
    bit                pix_mem [0:PIX_DEPTH-1];
    dqnc_pkg::t_status blk_mem [0:BLK_DEPTH-1];
    int unsigned       n_mixed;
    logic [3:0]        size_reg;

    t_count_result pending_counts[$];
    t_count_result want;
    int unsigned   idle_pct      = 25;
    int unsigned   out_stall_pct = 25;
    int unsigned   items_taken   = 0;
    int unsigned   counts_seen   = 0;
    int unsigned   err_cnt       = 0;
    int unsigned   quiet_cycles  = 0;

    dynamic_quadtree_node_count_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_pixel_value    (i_pixel_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_node_count     (o_node_count),
        .o_bad_coordinate (o_bad_coordinate)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic int unsigned size_now();
        return (size_reg > MAX_LOG2) ? MAX_LOG2 : 32'(size_reg);
    endfunction

    function automatic void wipe_image(input logic [3:0] new_size);
        size_reg = new_size;
        foreach (pix_mem[k]) pix_mem[k] = 1'b0;
        foreach (blk_mem[k]) blk_mem[k] = dqnc_pkg::ST_WHITE;
        n_mixed = 0;
    endfunction

    // Blocks d levels below the root start after all shallower layers
    function automatic int unsigned blk_slot(input int unsigned s, lvl, br, bc);
        int unsigned d;
        d = s - lvl;
        return ((((1 << (2 * d)) - 1) / 3) + ((br << d) | bc)) % BLK_DEPTH;
    endfunction

    function automatic dqnc_pkg::t_status quad_state(input int unsigned s, lvl, br, bc);
        if (lvl == 0) begin
            return dqnc_pkg::t_status'(pix_mem[((br << s) | bc) % PIX_DEPTH]);
        end
        return blk_mem[blk_slot(s, lvl, br, bc)];
    endfunction

    // Recompute every block on the path from the pixel up to the root
    function automatic void refresh_path(input int unsigned s, r, c);
        int unsigned lvl, br, bc, slot;
        dqnc_pkg::t_status q0, q1, q2, q3, merged, old;
        for (lvl = 1; lvl <= s; lvl++) begin
            br = r >> lvl;
            bc = c >> lvl;
            q0 = quad_state(s, lvl - 1, 2 * br, 2 * bc);
            q1 = quad_state(s, lvl - 1, 2 * br, 2 * bc + 1);
            q2 = quad_state(s, lvl - 1, 2 * br + 1, 2 * bc);
            q3 = quad_state(s, lvl - 1, 2 * br + 1, 2 * bc + 1);
            merged = dqnc_pkg::ST_MIXED;
            if (q0 == q1 && q1 == q2 && q2 == q3 && q0 != dqnc_pkg::ST_MIXED) begin
                merged = q0;
            end
            slot = blk_slot(s, lvl, br, bc);
            old = blk_mem[slot];
            if (old == dqnc_pkg::ST_MIXED && merged != dqnc_pkg::ST_MIXED) begin
                n_mixed--;
            end else if (old != dqnc_pkg::ST_MIXED && merged == dqnc_pkg::ST_MIXED) begin
                n_mixed++;
            end
            blk_mem[slot] = merged;
        end
    endfunction

    // Apply one item; return 1 when it produces a count
    function automatic bit apply_pixel_item(input logic cmd, input logic [7:0] row, col,
                                            input logic val, output t_count_result res);
        int unsigned s, side, idx;
        bit bad;
        s = size_now();
        side = 1 << s;
        bad = (row >= side) || (col >= side);
        if (!bad) begin
            idx = ((32'(row) << s) | 32'(col)) % PIX_DEPTH;
            pix_mem[idx] = (cmd == dqnc_pkg::CMD_FLIP) ? !pix_mem[idx] : val;
            refresh_path(s, 32'(row), 32'(col));
        end
        res.node_count = 17'(1 + 4 * n_mixed);
        res.bad_coordinate = bad;
        return cmd == dqnc_pkg::CMD_FLIP;
    endfunction

    // ------------------------------------------------------------- drivers

    // Present one item, hold it until taken, then predict its count
    task automatic send_item(input logic cmd, input logic [7:0] row, col, input logic val);
        t_count_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_row         <= row;
        i_col         <= col;
        i_pixel_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (apply_pixel_item(cmd, row, col, val, res)) begin
            pending_counts.push_back(res);
        end
        if (!(res.bad_coordinate && cmd == dqnc_pkg::CMD_LOAD)) begin
            items_taken++;
        end
    endtask

    // Drop valid and let every outstanding count come back, then let loads finish
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_counts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [3:0] new_size);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= new_size;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        wipe_image(new_size);
    endtask

    // Mostly whole-block fills followed by flips, the rest loose items and noise
    task automatic run_random(input int unsigned n);
        int unsigned s, side, start, lvl, bsz, r0, c0, i, j, mask;
        logic colour;
        logic [7:0] row, col;
        s = size_now();
        side = 1 << s;
        start = items_taken;
        while (items_taken - start < n) begin
            if (s != 0 && $urandom_range(99) < 30) begin
                lvl  = $urandom_range(1, (s < 2) ? s : 2);
                bsz  = 1 << lvl;
                r0   = $urandom_range(0, side / bsz - 1) * bsz;
                c0   = $urandom_range(0, side / bsz - 1) * bsz;
                mask = $urandom_range(0, bsz - 1);
                colour = 1'($urandom_range(1));
                for (i = 0; i < bsz; i++) begin
                    for (j = 0; j < bsz; j++) begin
                        send_item(dqnc_pkg::CMD_LOAD, 8'(r0 + (i ^ mask)),
                                  8'(c0 + (j ^ mask)), colour);
                    end
                end
                row = 8'(r0 + $urandom_range(0, bsz - 1));
                col = 8'(c0 + $urandom_range(0, bsz - 1));
                send_item(dqnc_pkg::CMD_FLIP, row, col, 1'($urandom_range(1)));
                if ($urandom_range(1)) begin
                    send_item(dqnc_pkg::CMD_FLIP, row, col, 1'($urandom_range(1)));
                end
            end else begin
                if ($urandom_range(99) < 15) begin
                    row = 8'($urandom_range(255));
                    col = 8'($urandom_range(255));
                end else begin
                    row = 8'($urandom_range(0, side - 1));
                    col = 8'($urandom_range(0, side - 1));
                end
                send_item(($urandom_range(99) < 60) ? dqnc_pkg::CMD_FLIP : dqnc_pkg::CMD_LOAD,
                          row, col, 1'($urandom_range(1)));
            end
        end
    endtask

    // --------------------------------------------------------------- tests

    // Full size after reset: corners, loads that set and clear a pixel
    task automatic test_default_size();
        send_item(dqnc_pkg::CMD_FLIP, 8'd0, 8'd0, 1'b0);
        send_item(dqnc_pkg::CMD_FLIP, 8'd255, 8'd255, 1'b1);
        send_item(dqnc_pkg::CMD_LOAD, 8'd128, 8'd77, 1'b1);
        send_item(dqnc_pkg::CMD_FLIP, 8'd255, 8'd0, 1'b0);
        send_item(dqnc_pkg::CMD_LOAD, 8'd128, 8'd77, 1'b0);
        send_item(dqnc_pkg::CMD_FLIP, 8'd0, 8'd0, 1'b1);
    endtask

    // One pixel image: count stays 1, anything off the origin is flagged
    task automatic test_single_pixel();
        write_size(4'd0);
        send_item(dqnc_pkg::CMD_FLIP, 8'd0, 8'd0, 1'b0);
        send_item(dqnc_pkg::CMD_FLIP, 8'd0, 8'd1, 1'b0);
        send_item(dqnc_pkg::CMD_FLIP, 8'd1, 8'd0, 1'b1);
        send_item(dqnc_pkg::CMD_LOAD, 8'd0, 8'd0, 1'b1);
        send_item(dqnc_pkg::CMD_LOAD, 8'd5, 8'd0, 1'b1);
        send_item(dqnc_pkg::CMD_FLIP, 8'd255, 8'd255, 1'b0);
    endtask

    // Side two: fill to uniform black, split it again, out-of-range flip
    task automatic test_quad_merge();
        write_size(4'd1);
        send_item(dqnc_pkg::CMD_LOAD, 8'd0, 8'd0, 1'b1);
        send_item(dqnc_pkg::CMD_LOAD, 8'd0, 8'd1, 1'b1);
        send_item(dqnc_pkg::CMD_LOAD, 8'd1, 8'd0, 1'b1);
        send_item(dqnc_pkg::CMD_FLIP, 8'd1, 8'd1, 1'b0);
        send_item(dqnc_pkg::CMD_FLIP, 8'd1, 8'd1, 1'b0);
        send_item(dqnc_pkg::CMD_FLIP, 8'd2, 8'd0, 1'b1);
    endtask

    // Size codes above the maximum behave as the maximum
    task automatic test_size_saturation();
        write_size(4'd15);
        send_item(dqnc_pkg::CMD_FLIP, 8'd200, 8'd13, 1'b0);
        send_item(dqnc_pkg::CMD_FLIP, 8'd255, 8'd255, 1'b0);
        send_item(dqnc_pkg::CMD_LOAD, 8'd127, 8'd128, 1'b1);
        send_item(dqnc_pkg::CMD_FLIP, 8'd127, 8'd129, 1'b1);
    endtask

    // Sender holds off mid-stream until every count has come back
    task automatic test_pressure_pause();
        write_size(4'd2);
        run_random(40);
        drain_results();
        run_random(40);
    endtask

    // Long stretch with neither side idling, at full size
    task automatic test_no_idle_stretch();
        idle_pct      = 0;
        out_stall_pct = 0;
        write_size(4'd8);
        run_random(120);
        idle_pct      = 25;
        out_stall_pct = 25;
    endtask

    task automatic test_random_sizes();
        write_size(4'd3);
        run_random(100);
        write_size(4'd1);
        run_random(40);
        write_size(4'd5);
        run_random(60);
        write_size(4'd11);
        run_random(50);
    endtask

    // ------------------------------------------------------------ checking

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Compare each count taken with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_counts.size() == 0) begin
                $error("unexpected count %0d (bad_coordinate %0b)",
                       o_node_count, o_bad_coordinate);
                err_cnt++;
            end else begin
                want = pending_counts.pop_front();
                counts_seen++;
                if (o_node_count !== want.node_count) begin
                    $error("node_count: expected %0d, got %0d",
                           want.node_count, o_node_count);
                    err_cnt++;
                end
                if (o_bad_coordinate !== want.bad_coordinate) begin
                    $error("bad_coordinate: expected %0b, got %0b",
                           want.bad_coordinate, o_bad_coordinate);
                    err_cnt++;
                end
            end
        end
    end

    // Give up after too long with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("dynamic_quadtree_node_count_unit_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wipe_image(4'(dqnc_pkg::SIZE_LOG2_RESET));
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_size();
        test_single_pixel();
        test_quad_merge();
        test_size_saturation();
        test_pressure_pause();
        test_no_idle_stretch();
        test_random_sizes();
        drain_results();

        $display("summary: %0d items taken, %0d counts checked", items_taken, counts_seen);
        $display("sizes 0, 1, 2, 3, 5, 8, 11 and 15 used, with and without idling");
        if (err_cnt == 0) begin
            $display("dynamic_quadtree_node_count_unit_tb: clean");
        end else begin
            $display("dynamic_quadtree_node_count_unit_tb: errors");
        end
        $finish;
    end

endmodule
